/* hdl/dedup_waitlist_fifo_assert.svh */
// Assertion macros shared by the waitlist RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef DEDUP_WAITLIST_FIFO_ASSERT_SVH
`define DEDUP_WAITLIST_FIFO_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define DWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dwf_pkg.sv */
// Shared types and codes for the deduplicating waitlist FIFO.
// Depends on nothing; imported by dwf_cell and dedup_waitlist_fifo.
package dwf_pkg;

    localparam int DWF_DEPTH_DEFAULT = 16;

    // Request operations
    localparam logic [1:0] MODE_ENQ    = 2'd0;
    localparam logic [1:0] MODE_DEQ    = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    // Response status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] user_key;
        logic [31:0] payload_tag;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_key;
        logic [31:0] out_tag;
        logic [4:0]  occupancy;
        logic        is_empty;
    } t_rsp;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } t_cell_cmd;

endpackage

/* hdl/dedup_waitlist_fifo.sv */
// Top level of the deduplicating waitlist FIFO: a chain of dwf_cell slots.
// Depends on dwf_pkg, dwf_cell and dedup_waitlist_fifo_assert.svh.
//
//   channel   direction   handshake                  payload
//   request   in          i_in_valid / o_in_stall    i_in_req  (t_req)
//   response  out         o_out_valid / i_out_stall  o_out_rsp (t_rsp)
//
// Each accepted request has its response registered for the next cycle;
// one request per cycle is sustained while responses are drained.
// All slots compare the id at once and shift up together, so the response
// timing does not depend on queue depth.
// Synchronous active-low reset empties the queue; slot contents are left as is.
// A stalled response holds and stalls the request side until taken.
`include "dedup_waitlist_fifo_assert.svh"

module dedup_waitlist_fifo
    import dwf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DWF_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_rsp          r_rsp;
    t_rsp          n_rsp;

    logic             w_accept;
    logic             w_hit;
    logic             w_full;
    logic             w_empty;
    t_cell_cmd        w_cmd;
    logic [31:0]      w_key   [QUEUE_DEPTH];
    logic [31:0]      w_tag   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_gap;
    logic [31:0]      w_occ32;

    // Accept a request when the response register is free or draining
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_full  = (r_count == FULL_CNT);
    assign w_empty = (r_count == '0);
    assign w_hit   = w_gap[QUEUE_DEPTH-1];

    // Decode the chain command
    always_comb begin
        w_cmd        = '0;
        w_cmd.push   = w_accept && (i_in_req.mode == MODE_ENQ) && !w_hit && !w_full;
        w_cmd.pop    = w_accept && (i_in_req.mode == MODE_DEQ) && !w_empty;
        w_cmd.remove = w_accept && (i_in_req.mode == MODE_REMOVE) && w_hit;
    end

    // Build the row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic        w_prev_valid;
        logic        w_gap_in;
        logic [31:0] w_next_key;
        logic [31:0] w_next_tag;
        logic        w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
            assign w_gap_in     = 1'b0;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
            assign w_gap_in     = w_gap[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_key   = '0;
            assign w_next_tag   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_link
            assign w_next_key   = w_key[g+1];
            assign w_next_tag   = w_tag[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        dwf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_cmp_key    (i_in_req.user_key),
            .i_new_key    (i_in_req.user_key),
            .i_new_tag    (i_in_req.payload_tag),
            .i_prev_valid (w_prev_valid),
            .i_gap_in     (w_gap_in),
            .i_next_key   (w_next_key),
            .i_next_tag   (w_next_tag),
            .i_next_valid (w_next_valid),
            .o_key        (w_key[g]),
            .o_tag        (w_tag[g]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g]),
            .o_gap_out    (w_gap[g])
        );
    end

    // Track the entry count
    always_comb begin
        n_count = r_count;
        if (w_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.pop || w_cmd.remove) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_occ32 = 32'(n_count);

    // Form the response
    always_comb begin
        n_rsp           = '0;
        n_rsp.status    = ST_OK;
        n_rsp.occupancy = w_occ32[4:0];
        n_rsp.is_empty  = (n_count == '0);
        case (i_in_req.mode)
            MODE_ENQ: begin
                if (w_hit) begin
                    n_rsp.status = ST_DUP;
                end else if (w_full) begin
                    n_rsp.status = ST_FULL;
                end
            end
            MODE_DEQ: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.out_key = w_key[0];
                    n_rsp.out_tag = w_tag[0];
                end
            end
            MODE_LOOKUP, MODE_REMOVE: begin
                if (!w_hit) begin
                    n_rsp.status = ST_MISSING;
                end
            end
            default: begin
                n_rsp.status = ST_OK;
            end
        endcase
    end

    // Hold count and response valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the response payload on each accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    // Checks on the chain and the count
    `DWF_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "count over depth")
    `DWF_ASSERT_NOW(a_valid_count, i_clk, i_rst_n, 1'b1, $countones(w_valid) == 32'(r_count), "valid bits disagree with count")
    `DWF_ASSERT_NOW(a_unique_ids, i_clk, i_rst_n, 1'b1, $onehot0(w_match), "id queued twice")
    `DWF_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_cmd.push, r_count == $past(r_count) + CW'(1), "push did not grow count")

endmodule

/* hdl/dwf_cell.sv */
// One slot of the waitlist chain: holds an id, a tag and a valid bit.
// Depends on dwf_pkg; instantiated in a row by dedup_waitlist_fifo.
module dwf_cell
    import dwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_cmd   i_cmd,
    input  logic [31:0] i_cmp_key,
    input  logic [31:0] i_new_key,
    input  logic [31:0] i_new_tag,
    input  logic        i_prev_valid,
    input  logic        i_gap_in,
    input  logic [31:0] i_next_key,
    input  logic [31:0] i_next_tag,
    input  logic        i_next_valid,
    output logic [31:0] o_key,
    output logic [31:0] o_tag,
    output logic        o_valid,
    output logic        o_match,
    output logic        o_gap_out
);

    logic [31:0] r_key;
    logic [31:0] r_tag;
    logic        r_valid;
    logic        w_shift;
    logic        w_load;

    // Compare the held id and pass the gap flag on to the next cell
    assign o_match   = r_valid && (r_key == i_cmp_key);
    assign o_gap_out = i_gap_in | o_match;

    // Move up on a pop, or on a remove at or below the matching slot
    assign w_shift = i_cmd.pop | (i_cmd.remove & o_gap_out);
    // Take a new entry when this is the first free slot
    assign w_load  = i_cmd.push & ~r_valid & i_prev_valid;

    // Hold valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_next_valid;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end
    end

    // Advance or load the payload
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key <= i_next_key;
            r_tag <= i_next_tag;
        end else if (w_load) begin
            r_key <= i_new_key;
            r_tag <= i_new_tag;
        end
    end

    assign o_key   = r_key;
    assign o_tag   = r_tag;
    assign o_valid = r_valid;

endmodule
